// ===== sv/md5_message_digest_macros.svh =====
// Assertion macros for the MD5 digest block.
// Used by the checker module; depends on nothing else.
`ifndef MD5_MESSAGE_DIGEST_MACROS_SVH
`define MD5_MESSAGE_DIGEST_MACROS_SVH
// implication checked on every clock edge outside reset
`define MD5_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define MD5_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== sv/md5_pkg.sv =====
// Package for the MD5 digest block: constants, tables and control structs.
// No dependencies.
package md5_pkg;
	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef enum logic [2:0] {
		ST_IDLE, ST_COMPRESS, ST_PAD, ST_OUT0, ST_OUT1
	} md5_state_t;

	typedef enum logic [1:0] {
		SRC_DATA, SRC_PAD, SRC_ZERO, SRC_LEN
	} byte_src_t;

	typedef struct packed {
		logic      push;
		byte_src_t src;
		logic      round_start;
		logic      round_step;
		logic      round_finish;
		logic      count_byte;
		logic      reinit;
	} md5_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic [5:0] round;
		logic       round_last;
	} md5_status_t;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k;
		unique case (i)
			6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
			6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
			6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
			default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] round_shift(input logic [5:0] i);
		logic [4:0] s;
		unique case ({i[5:4], i[1:0]})
			4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
			4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
			4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
		endcase
		return s;
	endfunction

	function automatic logic [3:0] word_index(input logic [5:0] i);
		logic [3:0] r;
		unique case (i[5:4])
			2'd0: r = i[3:0];
			2'd1: r = 4'(5 * i[3:0] + 1);
			2'd2: r = 4'(3 * i[3:0] + 5);
			default: r = 4'(7 * i[3:0]);
		endcase
		return r;
	endfunction
endpackage

// ===== sv/md5_if.sv =====
// Valid/ready channel interface for the MD5 block.
// Payload type is a parameter; no package dependency.
interface md5_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (input clk, output valid, output payload, input ready);
	modport sink (input clk, input valid, input payload, output ready);
endinterface

// ===== sv/md5_datapath.sv =====
// MD5 datapath: block buffer, counters, round registers and chaining words.
// Depends on md5_pkg.
module md5_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  md5_pkg::md5_cmd_t     cmd,
	input  logic [7:0]            data_byte,
	output md5_pkg::md5_status_t  status,
	output logic [127:0]          digest
);
	logic [31:0] mem [16];
	logic [5:0]  fill_q;
	logic [5:0]  round_q;
	logic [60:0] total_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] h0_q, h1_q, h2_q, h3_q;
	logic [31:0] w_q;
	logic [7:0]  push_byte;
	logic [63:0] bits;
	logic [31:0] f, sum, rot;
	logic [3:0]  widx;
	logic [5:0]  next_round;

	assign bits = {total_q, 3'b000};

	always_comb begin
		case (cmd.src)
			md5_pkg::SRC_DATA: push_byte = data_byte;
			md5_pkg::SRC_PAD:  push_byte = md5_pkg::PAD_BYTE;
			md5_pkg::SRC_ZERO: push_byte = 8'h00;
			default:           push_byte = bits[{fill_q[2:0], 3'b000} +: 8];
		endcase
	end

	// store little-endian: byte n of the block goes to lane n[1:0] of word n[5:2]
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[fill_q[5:2]][{fill_q[1:0], 3'b000} +: 8] <= push_byte;
		end
	end

	// fetch the message word of the round after the current one
	assign next_round = cmd.round_start ? 6'd0 : round_q + 6'd1;
	assign widx = md5_pkg::word_index(next_round);
	always_ff @(posedge clk) begin
		w_q <= mem[widx];
	end

	always_comb begin
		unique case (round_q[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (d_q & b_q) | (~d_q & c_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		sum = a_q + f + md5_pkg::round_k(round_q) + w_q;
		rot = 32'(({sum, sum} << md5_pkg::round_shift(round_q)) >> 32);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			total_q <= '0;
			round_q <= '0;
			h0_q <= md5_pkg::INIT_A;
			h1_q <= md5_pkg::INIT_B;
			h2_q <= md5_pkg::INIT_C;
			h3_q <= md5_pkg::INIT_D;
		end else begin
			if (cmd.push) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.count_byte) begin
				total_q <= total_q + 61'd1;
			end
			if (cmd.round_start) begin
				round_q <= '0;
			end else if (cmd.round_step) begin
				round_q <= round_q + 6'd1;
			end
			// fold in the words as they stand after the last round
			if (cmd.round_finish) begin
				h0_q <= h0_q + d_q;
				h1_q <= h1_q + b_q + rot;
				h2_q <= h2_q + b_q;
				h3_q <= h3_q + c_q;
			end
			if (cmd.reinit) begin
				fill_q  <= '0;
				total_q <= '0;
				h0_q <= md5_pkg::INIT_A;
				h1_q <= md5_pkg::INIT_B;
				h2_q <= md5_pkg::INIT_C;
				h3_q <= md5_pkg::INIT_D;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.round_start) begin
			a_q <= h0_q;
			b_q <= h1_q;
			c_q <= h2_q;
			d_q <= h3_q;
		end else if (cmd.round_step) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= b_q + rot;
		end
	end

	assign status = '{fill: fill_q, round: round_q, round_last: (round_q == 6'd63)};
	assign digest = {h3_q, h2_q, h1_q, h0_q};
endmodule

// ===== sv/md5_ctrl.sv =====
// MD5 controller: sequences byte intake, compression, padding and output.
// Depends on md5_pkg.
module md5_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_present,
	input  logic                 in_end,
	output logic                 in_ready,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic                 out_index,
	input  md5_pkg::md5_status_t status,
	output md5_pkg::md5_cmd_t    cmd
);
	md5_pkg::md5_state_t state_q, state_d;
	logic                padding_q, padding_d;
	logic                pad_first_q, pad_first_d;
	logic                wait_q, wait_d;
	logic                zero_tail_q, zero_tail_d;
	logic                last_block_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= md5_pkg::ST_IDLE;
			padding_q   <= 1'b0;
			pad_first_q <= 1'b0;
			wait_q      <= 1'b0;
			zero_tail_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			padding_q   <= padding_d;
			pad_first_q <= pad_first_d;
			wait_q      <= wait_d;
			zero_tail_q <= zero_tail_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		padding_d   = padding_q;
		pad_first_d = pad_first_q;
		zero_tail_d = zero_tail_q;
		wait_d      = 1'b0;
		cmd         = '0;
		cmd.src     = md5_pkg::SRC_DATA;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		out_index   = 1'b0;
		unique case (state_q)
			md5_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.push       = in_present;
					cmd.count_byte = in_present;
					pad_first_d    = 1'b1;
					if (in_present && status.fill == 6'd63) begin
						// block full: first word fetch goes with the start
						state_d   = md5_pkg::ST_COMPRESS;
						padding_d = in_end;
						wait_d    = 1'b1;
					end else if (in_end) begin
						state_d   = md5_pkg::ST_PAD;
						padding_d = 1'b1;
					end
				end
			end
			md5_pkg::ST_COMPRESS: begin
				// load the words and the first message word, then 64 rounds
				if (wait_q) begin
					cmd.round_start = 1'b1;
				end else begin
					cmd.round_step = 1'b1;
					if (status.round_last) begin
						cmd.round_finish = 1'b1;
						state_d = padding_q ? md5_pkg::ST_PAD : md5_pkg::ST_IDLE;
					end
				end
			end
			md5_pkg::ST_PAD: begin
				cmd.push = 1'b1;
				if (pad_first_q) begin
					cmd.src     = md5_pkg::SRC_PAD;
					pad_first_d = 1'b0;
					// no room for the length behind the 0x80: zero to the block end
					zero_tail_d = (status.fill >= 6'd56);
				end else if (status.fill >= 6'd56 && !zero_tail_q) begin
					cmd.src = md5_pkg::SRC_LEN;
				end else begin
					cmd.src = md5_pkg::SRC_ZERO;
				end
				if (status.fill == 6'd63) begin
					state_d     = md5_pkg::ST_COMPRESS;
					wait_d      = 1'b1;
					zero_tail_d = 1'b0;
					// the length is in once the 0x80 is behind and fill wrapped at 64
					padding_d = !(cmd.src == md5_pkg::SRC_LEN);
				end
			end
			md5_pkg::ST_OUT0: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = md5_pkg::ST_OUT1;
				end
			end
			md5_pkg::ST_OUT1: begin
				out_valid = 1'b1;
				out_index = 1'b1;
				if (out_ready) begin
					cmd.reinit = 1'b1;
					state_d    = md5_pkg::ST_IDLE;
				end
			end
			default: state_d = md5_pkg::ST_IDLE;
		endcase
		// the final compression leads to output instead of idle
		if (state_q == md5_pkg::ST_COMPRESS && !wait_q && status.round_last && !padding_q
				&& last_block_q) begin
			state_d = md5_pkg::ST_OUT0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_block_q <= 1'b0;
		end else if (state_q == md5_pkg::ST_PAD && status.fill == 6'd63) begin
			last_block_q <= (cmd.src == md5_pkg::SRC_LEN);
		end else if (state_q == md5_pkg::ST_OUT1) begin
			last_block_q <= 1'b0;
		end
	end
endmodule

// ===== sv/md5_message_digest.sv =====
// channel | dir | payload
// in_ch   | in  | data_byte, byte_present, end_of_message
// out_ch  | out | digest_part, part_index, last_part
// A plain byte goes into the block buffer; the byte that fills a block starts
// the 64-round compression (one round a cycle). End of message pads a
// byte a cycle, compresses one or two blocks, then offers two digest halves.
// Reset loads the initial chaining words and clears the counters; no clearing pass. A stalled
// output holds the block; input is refused until both halves are taken.
// Depends on md5_pkg, md5_if, md5_ctrl and md5_datapath.
module md5_message_digest (
	input logic clk,
	input logic arst_n,
	md5_if.sink   in_ch,
	md5_if.source out_ch
);
	md5_pkg::md5_cmd_t    cmd;
	md5_pkg::md5_status_t status;
	logic [127:0]         digest;
	logic                 out_index;

	md5_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid),
		.in_present(in_ch.payload.byte_present),
		.in_end(in_ch.payload.end_of_message),
		.in_ready(in_ch.ready),
		.out_ready(out_ch.ready),
		.out_valid(out_ch.valid),
		.out_index(out_index),
		.status, .cmd
	);

	md5_datapath u_dp (
		.clk, .arst_n, .cmd,
		.data_byte(in_ch.payload.data_byte),
		.status, .digest
	);

	assign out_ch.payload.digest_part = out_index ? digest[127:64] : digest[63:0];
	assign out_ch.payload.part_index  = out_index;
	assign out_ch.payload.last_part   = out_index;
endmodule

// ===== sv/md5_checker.sv =====
// Port checker for the MD5 digest block, bound to the top level.
// Depends on md5_message_digest_macros.svh.
`include "md5_message_digest_macros.svh"
module md5_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic part_index,
	input logic last_part
);
	`MD5_ASSERT_IMPL(a_no_overlap, clk, arst_n, out_valid, !in_ready, "input open during output")
	`MD5_ASSERT_IMPL(a_last_idx, clk, arst_n, out_valid, last_part == part_index, "last_part mismatch")
	`MD5_ASSERT_NEXT(a_half_order, clk, arst_n, out_valid && out_ready && !part_index, out_valid && part_index, "second half missing")
	`MD5_ASSERT_NEXT(a_after_last, clk, arst_n, out_valid && out_ready && part_index, !out_valid, "extra transfer")
endmodule

bind md5_message_digest md5_checker u_md5_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
	.out_ready(out_ch.ready), .part_index(out_ch.payload.part_index),
	.last_part(out_ch.payload.last_part)
);
